// ===== hw/rtl/tli_pkg.sv =====
package tli_pkg;

	// mark bytes
	localparam logic [7:0] BYTE_FF = 8'hFF;
	localparam logic [7:0] BYTE_FE = 8'hFE;
	localparam logic [7:0] BYTE_EF = 8'hEF;
	localparam logic [7:0] BYTE_BB = 8'hBB;
	localparam logic [7:0] BYTE_BF = 8'hBF;

	// code units of interest
	localparam logic [15:0] UNIT_LF = 16'h000A;
	localparam logic [15:0] UNIT_CR = 16'h000D;

	// encoding codes
	localparam logic [1:0] ENC_PLAIN    = 2'd0;
	localparam logic [1:0] ENC_UTF8_BOM = 2'd1;
	localparam logic [1:0] ENC_UTF16_LE = 2'd2;
	localparam logic [1:0] ENC_UTF16_BE = 2'd3;

	// record kinds
	localparam logic KIND_LINE    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// output tdata: value, encoding, unit count, line count, zero padding
	localparam int OUT_DATA_BITS = 104;

	typedef struct packed {
		logic        kind;
		logic [31:0] value;
		logic [1:0]  enc;
		logic [31:0] units;
		logic [31:0] lines;
		logic        last;
	} result_t;

endpackage

// ===== hw/rtl/text_line_indexer_unit.sv =====
// channel  dir  tdata                                       tuser        tlast
// s_*      in   [7:0] data_byte                             -            final_byte
// m_*      out  [31:0] value, [33:32] encoding,             record_kind  last_result
//               [65:34] unit_count, [97:66] line_count
//
// one input item per cycle sustained while the result queue has room; an item is held in the input
// register, then its results land in a four-entry result queue
// an item may give two results (line start and summary), which drain one per cycle while m_tready is high
// the input register advances only while the queue has room for two results
// arst_n resets the input valid, the queue pointers and all indexing state
// stalls on the master side fill the queue and then hold off s_tready
module text_line_indexer_unit #(
	parameter int POSITION_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // data_byte
	input  logic                             s_tlast,   // final_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [tli_pkg::OUT_DATA_BITS-1:0] m_tdata,  // value, encoding, unit_count, line_count
	output logic                             m_tuser,   // record_kind
	output logic                             m_tlast    // last_result
);
	import tli_pkg::*;

	localparam int P  = POSITION_BITS;
	localparam int PW = P + 1;
	localparam int EW = (P > 32) ? P : 33;

	// mark detection stages
	localparam logic [1:0] STG_NONE = 2'd0;  // nothing seen yet
	localparam logic [1:0] STG_HELD = 2'd1;  // one candidate mark byte held
	localparam logic [1:0] STG_EFBB = 2'd2;  // EF BB seen
	localparam logic [1:0] STG_DONE = 2'd3;  // mark settled

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
	localparam int CNT_BITS   = PTR_BITS + 1;
	localparam logic [CNT_BITS-1:0] ROOM_LIMIT = CNT_BITS'(FIFO_DEPTH - 2);

	// saturating add of a small step
	function automatic logic [P-1:0] sat_add(input logic [P-1:0] v, input logic [1:0] k);
		logic [P:0] s;
		s = {1'b0, v} + PW'(k);
		return s[P] ? {P{1'b1}} : s[P-1:0];
	endfunction

	// clamp a position to the 32-bit reporting range
	function automatic logic [31:0] out32(input logic [P-1:0] v);
		logic [EW-1:0] e;
		e = EW'(v);
		return (e > EW'(33'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF : e[31:0];
	endfunction

	// input register
	logic       v_s1;
	logic [7:0] byte_s1;
	logic       final_s1;

	// indexing state
	logic [1:0]   stage_q;
	logic [1:0]   enc_q;
	logic [7:0]   held_q;
	logic         half_q;
	logic [P-1:0] pos_q;
	logic [P-1:0] cls_q;
	logic         cr_q;
	logic [P-1:0] long_q;
	logic [31:0]  lines_q;

	// result queue
	result_t               fifo_q [FIFO_DEPTH];
	logic [PTR_BITS-1:0]   wr_q;
	logic [PTR_BITS-1:0]   rd_q;
	logic [CNT_BITS-1:0]   cnt_q;

	logic adv;
	logic pop;
	logic push0;
	logic push1;

	// next-state and result logic
	logic [1:0]   n_stage;
	logic [1:0]   n_enc;
	logic [7:0]   n_held;
	logic         n_half;
	logic [1:0]   pre;
	logic [1:0]   tail;
	logic [1:0]   step;
	logic         feed_plain;
	logic         feed_wide;
	logic         unit_ok;
	logic [15:0]  unit_val;
	logic         is_lf;
	logic         cr_eff;
	logic         n_cr;
	logic [P-1:0] p1;
	logic [P-1:0] p_unit;
	logic [P-1:0] pos_f;
	logic [P-1:0] len;
	logic [P-1:0] tail_len;
	logic [P-1:0] long_a;
	logic [P-1:0] long_f;
	logic [P-1:0] cls_a;
	logic [31:0]  lines_a;
	result_t      line_rec;
	result_t      sum_rec;
	result_t      res0;
	result_t      head;

	assign adv      = v_s1 && (cnt_q <= ROOM_LIMIT);
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			final_s1 <= s_tlast;
		end
	end

	always_comb begin
		n_stage    = stage_q;
		n_enc      = enc_q;
		n_held     = held_q;
		n_half     = half_q;
		pre        = 2'd0;
		tail       = 2'd0;
		feed_plain = 1'b0;
		feed_wide  = 1'b0;
		unit_ok    = 1'b0;
		unit_val   = {8'h00, byte_s1};

		// byte-order mark detection; held bytes are released as content on a mismatch
		unique case (stage_q)
			STG_NONE: begin
				if (byte_s1 == BYTE_FF || byte_s1 == BYTE_FE || byte_s1 == BYTE_EF) begin
					n_held  = byte_s1;
					n_stage = STG_HELD;
				end else begin
					n_enc      = ENC_PLAIN;
					n_stage    = STG_DONE;
					feed_plain = 1'b1;
				end
			end
			STG_HELD: begin
				n_stage = STG_DONE;
				if (held_q == BYTE_FF && byte_s1 == BYTE_FE) begin
					n_enc = ENC_UTF16_LE;
				end else if (held_q == BYTE_FE && byte_s1 == BYTE_FF) begin
					n_enc = ENC_UTF16_BE;
				end else if (held_q == BYTE_EF && byte_s1 == BYTE_BB) begin
					n_stage = STG_EFBB;
				end else begin
					n_enc      = ENC_PLAIN;
					pre        = 2'd1;
					feed_plain = 1'b1;
				end
			end
			STG_EFBB: begin
				n_stage = STG_DONE;
				if (byte_s1 == BYTE_BF) begin
					n_enc = ENC_UTF8_BOM;
				end else begin
					n_enc      = ENC_PLAIN;
					pre        = 2'd2;
					feed_plain = 1'b1;
				end
			end
			STG_DONE: begin
				if (enc_q == ENC_UTF16_LE || enc_q == ENC_UTF16_BE) begin
					feed_wide = 1'b1;
				end else begin
					feed_plain = 1'b1;
				end
			end
		endcase

		// code unit forming
		if (feed_plain) begin
			unit_ok = 1'b1;
		end
		if (feed_wide) begin
			if (!half_q) begin
				n_held = byte_s1;
				n_half = 1'b1;
			end else begin
				unit_ok  = 1'b1;
				unit_val = (enc_q == ENC_UTF16_LE) ? {byte_s1, held_q} : {held_q, byte_s1};
				n_half   = 1'b0;
			end
		end

		is_lf  = unit_ok && (unit_val == UNIT_LF);
		step   = pre + {1'b0, unit_ok};
		p1     = sat_add(pos_q, pre);
		p_unit = sat_add(pos_q, step);
		// released mark bytes are never CR
		cr_eff = (pre != 2'd0) ? 1'b0 : cr_q;
		n_cr   = unit_ok ? (unit_val == UNIT_CR) : cr_eff;

		len = p1 - cls_q;
		if (cr_eff && len != '0) begin
			len = len - 1'b1;
		end

		long_a  = long_q;
		cls_a   = cls_q;
		lines_a = lines_q;
		if (is_lf) begin
			long_a  = (len > long_q) ? len : long_q;
			cls_a   = p_unit;
			lines_a = (lines_q != 32'hFFFF_FFFF) ? lines_q + 32'd1 : lines_q;
		end

		// an undecided mark at end of file is plain content
		if (final_s1) begin
			if (n_stage == STG_HELD) begin
				tail  = 2'd1;
				n_enc = ENC_PLAIN;
			end else if (n_stage == STG_EFBB) begin
				tail  = 2'd2;
				n_enc = ENC_PLAIN;
			end
		end

		pos_f    = sat_add(pos_q, step + tail);
		tail_len = pos_f - cls_a;
		long_f   = (tail_len > long_a) ? tail_len : long_a;

		line_rec.kind  = KIND_LINE;
		line_rec.value = out32(cls_a);
		line_rec.enc   = n_enc;
		line_rec.units = 32'd0;
		line_rec.lines = 32'd0;
		line_rec.last  = 1'b0;

		sum_rec.kind  = KIND_SUMMARY;
		sum_rec.value = out32(long_f);
		sum_rec.enc   = n_enc;
		sum_rec.units = out32(pos_f);
		sum_rec.lines = lines_a;
		sum_rec.last  = 1'b1;

		res0 = is_lf ? line_rec : sum_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= STG_NONE;
			enc_q   <= ENC_PLAIN;
			held_q  <= 8'h00;
			half_q  <= 1'b0;
			pos_q   <= '0;
			cls_q   <= '0;
			cr_q    <= 1'b0;
			long_q  <= '0;
			lines_q <= 32'd1;
		end else if (adv) begin
			if (final_s1) begin
				// summary sent, next byte opens a new file
				stage_q <= STG_NONE;
				enc_q   <= ENC_PLAIN;
				held_q  <= 8'h00;
				half_q  <= 1'b0;
				pos_q   <= '0;
				cls_q   <= '0;
				cr_q    <= 1'b0;
				long_q  <= '0;
				lines_q <= 32'd1;
			end else begin
				stage_q <= n_stage;
				enc_q   <= n_enc;
				held_q  <= n_held;
				half_q  <= n_half;
				pos_q   <= p_unit;
				cls_q   <= cls_a;
				cr_q    <= n_cr;
				long_q  <= long_a;
				lines_q <= lines_a;
			end
		end
	end

	// result queue, up to two writes and one read per cycle
	assign push0 = adv && (is_lf || final_s1);
	assign push1 = adv && is_lf && final_s1;
	assign pop   = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (push0) begin
			fifo_q[wr_q] <= res0;
		end
		if (push1) begin
			fifo_q[PTR_BITS'(wr_q + 1'b1)] <= sum_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= PTR_BITS'(wr_q + PTR_BITS'(push0) + PTR_BITS'(push1));
			rd_q  <= PTR_BITS'(rd_q + PTR_BITS'(pop));
			cnt_q <= CNT_BITS'(cnt_q + CNT_BITS'(push0) + CNT_BITS'(push1) - CNT_BITS'(pop));
		end
	end

	assign head     = fifo_q[rd_q];
	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {6'b0, head.lines, head.units, head.enc, head.value};
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;

endmodule

// ===== hw/rtl/tli_checker.sv =====
module tli_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [tli_pkg::OUT_DATA_BITS-1:0] m_tdata,
	input logic                             m_tuser,
	input logic                             m_tlast
);
	import tli_pkg::*;

	// held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// only the summary closes a file
	a_line_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_LINE |-> !m_tlast)
		else $error("line record marked last");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_SUMMARY |-> m_tlast)
		else $error("summary not marked last");

	// line records carry no counts
	a_line_counts: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_LINE |-> m_tdata[97:34] == 64'd0)
		else $error("line record with counts");

	// a file always has at least one line
	a_summary_lines: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_SUMMARY |-> m_tdata[97:66] != 32'd0)
		else $error("summary with zero lines");

endmodule

bind text_line_indexer_unit tli_checker u_tli_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import tli_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 1450;
	localparam int CALM_FROM = 1230;   // last stretch runs with no idling on either side

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	int bytes_sent = 0;
	bit calm = 1'b0;
	bit out_of_reset = 1'b0;
	int cycles = 0;

	text_line_indexer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// line index predictor with its own copy of the indexing state
	class line_index_predictor;
		typedef enum bit [1:0] {MARK_NONE, MARK_ONE, MARK_EFBB, MARK_DONE} mark_t;

		bit [1:0]  seen;
		mark_t     stage;
		bit [1:0]  enc;
		bit [7:0]  held;
		bit        half;
		bit [31:0] pos;
		bit [31:0] line_start;
		bit        after_cr;
		bit [31:0] longest;
		bit [31:0] lines;
		result_t   expected_records[$];
		int        mismatches;

		function new();
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			seen = 2'd0;
			stage = MARK_NONE;
			enc = ENC_PLAIN;
			held = 8'h00;
			half = 1'b0;
			pos = 32'd0;
			line_start = 32'd0;
			after_cr = 1'b0;
			longest = 32'd0;
			lines = 32'd1;
		endfunction

		function bit [31:0] sat_inc(bit [31:0] v);
			return (v == '1) ? v : v + 32'd1;
		endfunction

		function void push_record(logic kind, bit [31:0] val, bit [31:0] units,
			bit [31:0] nlines, logic fin);
			result_t r;
			r.kind = kind;
			r.value = val;
			r.enc = enc;
			r.units = units;
			r.lines = nlines;
			r.last = fin;
			expected_records.insert(expected_records.size(), r);
		endfunction

		function void take_unit(bit [15:0] unit);
			bit [31:0] len;
			if (unit == UNIT_LF) begin
				len = pos - line_start;
				// a cr right before the lf is not part of the line
				if (after_cr && len != 0)
					len = len - 32'd1;
				if (len > longest)
					longest = len;
				line_start = sat_inc(pos);
				if (lines != '1)
					lines = lines + 32'd1;
				push_record(KIND_LINE, line_start, 32'd0, 32'd0, 1'b0);
			end
			after_cr = (unit == UNIT_CR);
			pos = sat_inc(pos);
		endfunction

		function void feed(bit [7:0] b);
			if (enc == ENC_UTF16_LE || enc == ENC_UTF16_BE) begin
				if (!half) begin
					held = b;
					half = 1'b1;
				end else begin
					half = 1'b0;
					if (enc == ENC_UTF16_LE)
						take_unit({b, held});
					else
						take_unit({held, b});
				end
			end else begin
				take_unit({8'h00, b});
			end
		endfunction

		function void note_byte(bit [7:0] b, bit fin);
			bit [31:0] tail;
			if (seen != 2'd3)
				seen = seen + 2'd1;
			case (stage)
				MARK_NONE: begin
					if (b == BYTE_FF || b == BYTE_FE || b == BYTE_EF) begin
						held = b;
						stage = MARK_ONE;
					end else begin
						enc = ENC_PLAIN;
						stage = MARK_DONE;
						feed(b);
					end
				end
				MARK_ONE: begin
					if (held == BYTE_FF && b == BYTE_FE) begin
						enc = ENC_UTF16_LE;
						stage = MARK_DONE;
					end else if (held == BYTE_FE && b == BYTE_FF) begin
						enc = ENC_UTF16_BE;
						stage = MARK_DONE;
					end else if (held == BYTE_EF && b == BYTE_BB) begin
						stage = MARK_EFBB;
					end else begin
						// no mark after all: the held byte is content
						enc = ENC_PLAIN;
						stage = MARK_DONE;
						feed(held);
						feed(b);
					end
				end
				MARK_EFBB: begin
					enc = (b == BYTE_BF) ? ENC_UTF8_BOM : ENC_PLAIN;
					stage = MARK_DONE;
					if (b != BYTE_BF) begin
						feed(BYTE_EF);
						feed(BYTE_BB);
						feed(b);
					end
				end
				default: feed(b);
			endcase
			if (fin) begin
				// an undecided mark at the end of the file is plain content
				if (stage == MARK_ONE) begin
					enc = ENC_PLAIN;
					stage = MARK_DONE;
					feed(held);
				end else if (stage == MARK_EFBB) begin
					enc = ENC_PLAIN;
					stage = MARK_DONE;
					feed(BYTE_EF);
					feed(BYTE_BB);
				end
				half = 1'b0;
				tail = pos - line_start;
				if (tail > longest)
					longest = tail;
				push_record(KIND_SUMMARY, longest, pos, lines, 1'b1);
				clear();
			end
		endfunction

		function void report(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %0h got %0h", $time, what, want, got);
		endfunction

		function void check_record(logic [OUT_DATA_BITS-1:0] data, logic kind, logic fin);
			result_t e;
			if (expected_records.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected record %0h kind %0b", $time, data, kind);
				return;
			end
			e = expected_records.pop_front();
			if (kind !== e.kind)
				report("record_kind", 32'(e.kind), 32'(kind));
			if (data[31:0] !== e.value)
				report("value", e.value, data[31:0]);
			if (data[33:32] !== e.enc)
				report("encoding", 32'(e.enc), 32'(data[33:32]));
			if (data[65:34] !== e.units)
				report("unit_count", e.units, data[65:34]);
			if (data[97:66] !== e.lines)
				report("line_count", e.lines, data[97:66]);
			if (data[OUT_DATA_BITS-1:98] !== '0)
				report("tdata padding", 32'd0, 32'(data[OUT_DATA_BITS-1:98]));
			if (fin !== e.last)
				report("last_result", 32'(e.last), 32'(fin));
		endfunction
	endclass

	line_index_predictor index_model = new();

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("text_line_indexer_unit: mismatch");
			$finish;
		end
	end

	// result side: check every accepted record against the oldest expectation
	always @(posedge clk)
		if (out_of_reset && m_tvalid && m_tready)
			index_model.check_record(m_tdata, m_tuser, m_tlast);

	// result side back-pressure in bursts
	initial begin
		wait (out_of_reset);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	// one file: the final byte carries tlast
	task automatic send_file(input bit [7:0] file_bytes[$]);
		for (int i = 0; i < file_bytes.size(); i++) begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= file_bytes[i];
			s_tlast <= (i == file_bytes.size() - 1);
			do
				@(posedge clk);
			while (!s_tready);
			index_model.note_byte(file_bytes[i], i == file_bytes.size() - 1);
			bytes_sent++;
			calm = (bytes_sent >= CALM_FROM);
		end
	endtask

	function automatic bit [7:0] text_byte();
		case ($urandom_range(0, 7))
			0, 1: return UNIT_LF[7:0];
			2: return UNIT_CR[7:0];
			default: return 8'($urandom());
		endcase
	endfunction

	function automatic bit [15:0] text_unit();
		case ($urandom_range(0, 9))
			0, 1: return UNIT_LF;
			2: return UNIT_CR;
			3: return {UNIT_LF[7:0], 8'h00};   // byte-swapped lf is no line break
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic send_random_file();
		bit [7:0] f[$];
		bit [15:0] u;
		int sel;
		int units;
		bit wide;
		bit big;
		sel = $urandom_range(0, 9);
		wide = 1'b0;
		big = 1'b0;
		case (sel)
			0, 1: begin
				f = '{BYTE_FF, BYTE_FE};
				wide = 1'b1;
			end
			2, 3: begin
				f = '{BYTE_FE, BYTE_FF};
				wide = 1'b1;
				big = 1'b1;
			end
			4, 5: f = '{BYTE_EF, BYTE_BB, BYTE_BF};
			6: begin
				// broken mark: a mark prefix, cut short or followed by a random byte
				case ($urandom_range(0, 3))
					0: f = '{BYTE_EF, BYTE_BB};
					1: f = '{BYTE_EF};
					2: f = '{BYTE_FF};
					default: f = '{BYTE_FE};
				endcase
				if ($urandom_range(0, 1))
					f.insert(f.size(), text_byte());
			end
			default: ;
		endcase
		units = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
		for (int i = 0; i < units; i++) begin
			if (wide) begin
				u = text_unit();
				if (big) begin
					f.insert(f.size(), u[15:8]);
					f.insert(f.size(), u[7:0]);
				end else begin
					f.insert(f.size(), u[7:0]);
					f.insert(f.size(), u[15:8]);
				end
			end else begin
				f.insert(f.size(), text_byte());
			end
		end
		// odd trailing byte in wide mode
		if (wide && $urandom_range(0, 3) == 0)
			f.insert(f.size(), text_byte());
		if (f.size() == 0)
			f.insert(f.size(), 8'($urandom()));
		send_file(f);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		out_of_reset = 1'b1;

		// directed files: lone lf, bare marks, partial mark, mark with content
		send_file('{UNIT_LF[7:0]});
		send_file('{BYTE_FF, BYTE_FE});
		send_file('{BYTE_FE, BYTE_FF});
		send_file('{BYTE_EF, BYTE_BB});
		send_file('{BYTE_FF});
		send_file('{BYTE_EF, BYTE_BB, UNIT_LF[7:0]});
		send_file('{BYTE_EF, BYTE_BB, BYTE_BF, UNIT_CR[7:0], UNIT_LF[7:0]});
		send_file('{BYTE_FF, UNIT_LF[7:0]});
		send_file('{BYTE_FF, BYTE_FE, UNIT_CR[7:0], 8'h00, UNIT_LF[7:0], 8'h00, 8'h41});

		while (bytes_sent < RANDOM_BYTES)
			send_random_file();
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		while (index_model.expected_records.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (index_model.mismatches == 0)
			$display("text_line_indexer_unit: match");
		else
			$display("text_line_indexer_unit: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/tli_pkg.sv
hw/rtl/text_line_indexer_unit.sv
hw/rtl/tli_checker.sv
tb/sv/tb.sv
